// ===== rtl/core/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared defaults and codes for the page frame allocator core.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int MAX_PAGES_DEF  = 4096;
  localparam int COUNT_BITS_DEF = 16;

  localparam int CFG_BITS = 13;

  localparam logic [CFG_BITS-1:0] NUM_PAGES_RST  = 13'd4096;
  localparam logic [CFG_BITS-1:0] IO_START_RST   = 13'd160;
  localparam logic [CFG_BITS-1:0] IO_END_RST     = 13'd256;
  localparam logic [CFG_BITS-1:0] KERNEL_END_RST = 13'd512;

  typedef enum logic [1:0] {
    CFG_NUM_PAGES  = 2'd0,
    CFG_IO_START   = 2'd1,
    CFG_IO_END     = 2'd2,
    CFG_KERNEL_END = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    REQ_INIT   = 3'd0,
    REQ_ALLOC  = 3'd1,
    REQ_INCREF = 3'd2,
    REQ_DECREF = 3'd3,
    REQ_FREE   = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_BUSY   = 3'd2,
    ST_BADIDX = 3'd3,
    ST_LIMIT  = 3'd4
  } status_t;

endpackage

// ===== rtl/core/page_frame_allocator_refcount_core.sv =====
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_core
// Page frame allocator with per-page reference counts and a LIFO free list.
// ----------------------------------------------------------------------------
// For alloc, incref, decref and free, the page's count word and the
// free-list link are read from RAM as the request is taken; the execute
// state then updates them and loads the result word once the output
// register is free. Init walks every one of the MAX_PAGES entries of the
// count RAM, one entry a cycle; until the first init the counts are
// undefined. A finished result word waits in the output register while the
// next request word is taken; only a second result then stalls on out_ready.
module page_frame_allocator_refcount_core
  import pfa_pkg::*;
#(
  parameter int MAX_PAGES  = MAX_PAGES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [12:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    req_type,
  input  logic [11:0]   page_index,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    status,
  output logic [11:0]   page_out,
  output logic [15:0]   ref_count
);

  localparam int AW = $clog2(MAX_PAGES);
  localparam int NW = (AW + 1 > CFG_BITS) ? AW + 1 : CFG_BITS;
  localparam int CB = COUNT_BITS;

  typedef enum logic [1:0] {S_IDLE, S_INIT, S_EXEC} state_t;

  state_t          state;
  logic [2:0]      req_r;
  logic [NW-1:0]   idx_r;
  logic [NW-1:0]   cnt;
  logic [AW-1:0]   head;
  logic [NW-1:0]   len;

  logic [CFG_BITS-1:0] num_pages;
  logic [CFG_BITS-1:0] io_start;
  logic [CFG_BITS-1:0] io_end;
  logic [CFG_BITS-1:0] kernel_end;

  logic          cnt_we;
  logic [AW-1:0] cnt_waddr;
  logic [CB:0]   cnt_wdata;
  logic [AW-1:0] cnt_raddr;
  logic [CB:0]   cnt_rdata;
  logic          lnk_we;
  logic [AW-1:0] lnk_waddr;
  logic [AW-1:0] lnk_rdata;

  logic [NW-1:0] active;
  logic [NW-1:0] in_idx;
  logic          go;
  logic          idx_ok;
  logic [CB-1:0] c;
  logic          onl;
  logic          init_in;
  logic          init_rsv;
  logic          init_push;
  logic          push;
  logic [2:0]    res_status;
  logic [11:0]   res_page;
  logic [CB-1:0] res_count;
  logic [AW-1:0] head_next;
  logic [NW-1:0] len_next;

  function automatic logic reserved(input logic [NW-1:0] p,
                                    input logic [CFG_BITS-1:0] hs,
                                    input logic [CFG_BITS-1:0] he,
                                    input logic [CFG_BITS-1:0] ke);
    logic in_hole;
    logic in_kern;
    in_hole = (p >= NW'(hs)) && (p < NW'(he));
    in_kern = p < NW'(ke);
    return (p == '0) || in_hole || in_kern;
  endfunction

  pfa_ram #(.WIDTH(CB + 1), .DEPTH(MAX_PAGES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  pfa_ram #(.WIDTH(AW), .DEPTH(MAX_PAGES)) u_lnk_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (head),
    .raddr (head),
    .rdata (lnk_rdata)
  );

  assign active   = (NW'(num_pages) < NW'(MAX_PAGES)) ? NW'(num_pages) : NW'(MAX_PAGES);
  assign in_idx   = NW'(page_index);
  assign in_ready = (state == S_IDLE);
  assign go       = !out_valid || out_ready;
  assign idx_ok   = idx_r < active;
  assign c        = cnt_rdata[CB-1:0];
  assign onl      = cnt_rdata[CB];
  assign cnt_raddr = (state == S_IDLE) ? in_idx[AW-1:0] : idx_r[AW-1:0];

  // init walk, one entry per cycle
  assign init_in   = cnt < active;
  assign init_rsv  = reserved(cnt, io_start, io_end, kernel_end);
  assign init_push = init_in && !init_rsv;

  always_comb begin
    cnt_we     = 1'b0;
    cnt_waddr  = idx_r[AW-1:0];
    cnt_wdata  = '0;
    lnk_we     = 1'b0;
    lnk_waddr  = idx_r[AW-1:0];
    push       = 1'b0;
    res_status = ST_OK;
    res_page   = idx_r[11:0];
    res_count  = idx_ok ? c : '0;
    head_next  = head;
    len_next   = len;
    if (state == S_INIT) begin
      cnt_we    = 1'b1;
      cnt_waddr = cnt[AW-1:0];
      // page 0 always starts with one reference
      cnt_wdata = {init_push, CB'((init_in && init_rsv) || (cnt == '0))};
      lnk_we    = init_push;
      lnk_waddr = cnt[AW-1:0];
    end else if (state == S_EXEC && go) begin
      case (req_r)
        REQ_INIT: begin
          res_count = (idx_ok && reserved(idx_r, io_start, io_end, kernel_end))
                      ? CB'(1) : '0;
        end
        REQ_ALLOC: begin
          res_count = '0;
          if (len == '0) begin
            res_status = ST_EMPTY;
            res_page   = '0;
          end else begin
            res_page  = 12'(head);
            cnt_we    = 1'b1;
            cnt_waddr = head;
            cnt_wdata = '0;
            len_next  = len - NW'(1);
            if (len != NW'(1)) begin
              head_next = lnk_rdata;
            end
          end
        end
        REQ_INCREF: begin
          if (!idx_ok) begin
            res_status = ST_BADIDX;
          end else if (c == '1) begin
            res_status = ST_LIMIT;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = {onl, c + CB'(1)};
            res_count = c + CB'(1);
          end
        end
        REQ_DECREF: begin
          if (!idx_ok) begin
            res_status = ST_BADIDX;
          end else if (c == '0) begin
            res_status = ST_LIMIT;
          end else begin
            push      = (c == CB'(1)) && !onl;
            cnt_we    = 1'b1;
            cnt_wdata = {onl || (c == CB'(1)), c - CB'(1)};
            res_count = c - CB'(1);
          end
        end
        REQ_FREE: begin
          if (!idx_ok) begin
            res_status = ST_BADIDX;
          end else if (c != '0) begin
            res_status = ST_BUSY;
          end else begin
            push      = !onl;
            cnt_we    = 1'b1;
            cnt_wdata = {1'b1, c};
          end
        end
        default: begin
        end
      endcase
      if (push) begin
        lnk_we    = 1'b1;
        head_next = idx_r[AW-1:0];
        len_next  = len + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      head       <= '0;
      len        <= '0;
      cnt        <= '0;
      num_pages  <= NUM_PAGES_RST;
      io_start   <= IO_START_RST;
      io_end     <= IO_END_RST;
      kernel_end <= KERNEL_END_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_NUM_PAGES:  num_pages  <= cfg_data;
          CFG_IO_START:   io_start   <= cfg_data;
          CFG_IO_END:     io_end     <= cfg_data;
          CFG_KERNEL_END: kernel_end <= cfg_data;
          default: begin
          end
        endcase
      end
      if (state == S_EXEC && go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_r <= req_type;
            idx_r <= in_idx;
            if (req_type == REQ_INIT) begin
              state <= S_INIT;
              cnt   <= '0;
              head  <= '0;
              len   <= '0;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_INIT: begin
          cnt <= cnt + NW'(1);
          if (init_push) begin
            head <= cnt[AW-1:0];
            len  <= len + NW'(1);
          end
          if (cnt == NW'(MAX_PAGES - 1)) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (go) begin
            status    <= res_status;
            page_out  <= res_page;
            ref_count <= 16'(res_count);
            head      <= head_next;
            len       <= len_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/pfa_ram.sv =====
// ----------------------------------------------------------------------------
// pfa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
